@@ src/audio_peak_rms_clip_meter_assert.svh @@
// Assertion macros for the checker file of the level meter.
`ifndef AUDIO_PEAK_RMS_CLIP_METER_ASSERT_SVH
`define AUDIO_PEAK_RMS_CLIP_METER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define APM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("level meter check failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define APM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("level meter check failed");

`endif

@@ src/apm_pkg.sv @@
// Package with the constants, codes and types of the level meter.
package apm_pkg;

  localparam int MaxChannels = 8;
  localparam int ChIdxW      = 3;
  localparam int ChCntW      = 4;
  localparam int MaxFrames   = 4096;
  localparam int FrameW      = 13;
  localparam int SampleW     = 24;
  localparam int SqW         = 48;
  localparam int SumW        = 59;
  localparam int PeriodW     = 25;
  localparam int CfgW        = 24;
  localparam int LevelW      = 32;

  localparam logic [26:0] C20Log = 27'd101008905;
  localparam logic [26:0] C10Log = 27'd50504453;
  localparam logic [31:0] DbFloor = 32'hFC19_0000;
  localparam logic [SampleW-1:0] FullScale = 24'h80_0000;

  typedef enum logic [2:0] {
    CFG_CHANNELS = 3'd0,
    CFG_PERIOD   = 3'd1,
    CFG_CLIP_RUN = 3'd2,
    CFG_HOT      = 3'd3,
    CFG_DB       = 3'd4,
    CFG_POWER    = 3'd5
  } apm_cfg_e;

  typedef enum logic [7:0] {
    T_IDLE = 8'b0000_0001,
    T_MUL  = 8'b0000_0010,
    T_UPD  = 8'b0000_0100,
    T_BEND = 8'b0000_1000,
    T_RMS  = 8'b0001_0000,
    T_PKDB = 8'b0010_0000,
    T_RMDB = 8'b0100_0000,
    T_EMIT = 8'b1000_0000
  } apm_top_state_e;

  typedef enum logic [7:0] {
    M_IDLE  = 8'b0000_0001,
    M_DIV   = 8'b0000_0010,
    M_SQRT  = 8'b0000_0100,
    M_NORM  = 8'b0000_1000,
    M_SQR   = 8'b0001_0000,
    M_SCALE = 8'b0010_0000,
    M_RND   = 8'b0100_0000,
    M_DONE  = 8'b1000_0000
  } apm_math_state_e;

  typedef struct packed {
    logic              start;
    logic              op_rms;
    logic              power;
    logic [SumW-1:0]   sum;
    logic [FrameW-1:0] frames;
    logic [SampleW-1:0] x;
  } apm_math_req_t;

  typedef struct packed {
    logic              done;
    logic [LevelW-1:0] result;
  } apm_math_rsp_t;

endpackage

@@ src/apm_stream_if.sv @@
// Stream interfaces for the sample input and the result output of the level meter.
interface apm_in_if
  import apm_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;
  logic [ChIdxW-1:0]  channel;
  logic               block_end;

  modport source (output valid, sample, channel, block_end, input ready);
  modport sink (input valid, sample, channel, block_end, output ready);
endinterface

interface apm_out_if
  import apm_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [ChIdxW-1:0]        out_channel;
  logic signed [LevelW-1:0] peak_level;
  logic signed [LevelW-1:0] rms_level;
  logic                     clipped;
  logic [FrameW-1:0]        head_run;
  logic [FrameW-1:0]        tail_run;
  logic [FrameW-1:0]        frame_count;
  logic                     last;

  modport source (output valid, out_channel, peak_level, rms_level, clipped, head_run,
                  tail_run, frame_count, last, input ready);
  modport sink (input valid, out_channel, peak_level, rms_level, clipped, head_run,
                tail_run, frame_count, last, output ready);
endinterface

@@ src/apm_math.sv @@
// Shared iterative unit: divide and square root for RMS, log2 and scaling for dB.
module apm_math
  import apm_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  apm_math_req_t req_i,
  output apm_math_rsp_t rsp_o
);

  apm_math_state_e state_q, state_d;
  logic [5:0]        cnt_q, cnt_d;
  logic [FrameW:0]   rem_q, rem_d;
  logic [SumW-1:0]   quo_q, quo_d;
  logic [FrameW-1:0] frames_q, frames_d;
  logic [59:0]       sv_q, sv_d, sres_q, sres_d, sbit_q, sbit_d;
  logic [30:0]       m_q, m_d;
  logic [4:0]        e_q, e_d;
  logic [19:0]       frac_q, frac_d;
  logic [63:0]       prod_q, prod_d;
  logic [LevelW-1:0] res_q, res_d;
  logic              power_q, power_d;

  logic [FrameW:0]   r2;
  logic              ge;
  logic [59:0]       st;
  logic [31:0]       mul_a, mul_b, m2;
  logic [63:0]       mul_p, rnd;
  logic [24:0]       lmag;

  assign r2    = {rem_q[FrameW-1:0], quo_q[SumW-1]};
  assign ge    = r2 >= {1'b0, frames_q};
  assign st    = sres_q + sbit_q;
  assign lmag  = {5'd23 - e_q, 20'd0} - {5'd0, frac_q};
  assign mul_a = state_q == M_SQR ? {1'b0, m_q} : {7'd0, lmag};
  assign mul_b = state_q == M_SQR ? {1'b0, m_q} : {5'd0, (power_q ? C10Log : C20Log)};
  assign mul_p = mul_a * mul_b;
  assign m2    = mul_p[61:30];
  assign rnd   = prod_q + 64'h0000_0000_0800_0000;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    frames_d = frames_q;
    sv_d     = sv_q;
    sres_d   = sres_q;
    sbit_d   = sbit_q;
    m_d      = m_q;
    e_d      = e_q;
    frac_d   = frac_q;
    prod_d   = prod_q;
    res_d    = res_q;
    power_d  = power_q;
    unique case (state_q)
      M_IDLE: begin
        if (req_i.start) begin
          power_d  = req_i.power;
          frames_d = req_i.frames;
          cnt_d    = '0;
          if (req_i.op_rms) begin
            if (req_i.frames == '0) begin
              res_d   = '0;
              state_d = M_DONE;
            end else begin
              quo_d   = req_i.sum;
              rem_d   = '0;
              state_d = M_DIV;
            end
          end else if (req_i.x == '0) begin
            res_d   = DbFloor;
            state_d = M_DONE;
          end else begin
            m_d     = {req_i.x, 7'd0};
            e_d     = 5'd23;
            frac_d  = '0;
            state_d = M_NORM;
          end
        end
      end
      M_DIV: begin
        rem_d = ge ? r2 - {1'b0, frames_q} : r2;
        quo_d = {quo_q[SumW-2:0], ge};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(SumW - 1)) begin
          sv_d    = {1'b0, quo_d};
          sres_d  = '0;
          sbit_d  = 60'd1 << 58;
          cnt_d   = '0;
          state_d = M_SQRT;
        end
      end
      M_SQRT: begin
        if (sv_q >= st) begin
          sv_d   = sv_q - st;
          sres_d = (sres_q >> 1) + sbit_q;
        end else begin
          sres_d = sres_q >> 1;
        end
        sbit_d = sbit_q >> 2;
        cnt_d  = cnt_q + 6'd1;
        if (cnt_q == 6'd29) begin
          res_d   = sres_d > {36'd0, FullScale} ? {8'd0, FullScale} : {8'd0, sres_d[23:0]};
          state_d = M_DONE;
        end
      end
      M_NORM: begin
        if (m_q[30]) begin
          cnt_d   = '0;
          state_d = M_SQR;
        end else begin
          m_d = {m_q[29:0], 1'b0};
          e_d = e_q - 5'd1;
        end
      end
      M_SQR: begin
        m_d    = m2[31] ? m2[31:1] : m2[30:0];
        frac_d = {frac_q[18:0], m2[31]};
        cnt_d  = cnt_q + 6'd1;
        if (cnt_q == 6'd19) begin
          state_d = M_SCALE;
        end
      end
      M_SCALE: begin
        prod_d  = mul_p;
        state_d = M_RND;
      end
      M_RND: begin
        res_d   = 32'd0 - rnd[59:28];
        state_d = M_DONE;
      end
      M_DONE: begin
        state_d = M_IDLE;
      end
      default: begin
        state_d = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    frames_q <= frames_d;
    sv_q     <= sv_d;
    sres_q   <= sres_d;
    sbit_q   <= sbit_d;
    m_q      <= m_d;
    e_q      <= e_d;
    frac_q   <= frac_d;
    prod_q   <= prod_d;
    res_q    <= res_d;
    power_q  <= power_d;
  end

  assign rsp_o.done   = state_q == M_DONE;
  assign rsp_o.result = res_q;

endmodule

@@ src/audio_peak_rms_clip_meter.sv @@
// Level meter top level: per-channel peak, RMS and clip tracking with periodic reports.
// A sample without block_end passes through accept, square and update; one with block_end
// adds a block-end step. When a period completes, each channel is reported in turn
// through one shared iterative unit: restoring division and square root, plus in dB
// mode two logarithms of up to 23 normalising steps, 20 squaring steps and a scaling
// and rounding step each. The input is not ready during that time; the output
// register lets the next channel be worked on while a result waits.
module audio_peak_rms_clip_meter
  import apm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [CfgW-1:0]   cfg_data_i,
  apm_in_if.sink            in_i,
  apm_out_if.source         out_o
);

  logic [ChCntW-1:0]  channels_q;
  logic [CfgW-1:0]    period_q;
  logic [11:0]        clip_run_q;
  logic [CfgW-1:0]    hot_q;
  logic               db_q, power_q;

  apm_top_state_e     state_q, state_d;
  logic [ChIdxW-1:0]  idx_q;
  logic               bend_q;
  logic [SampleW-1:0] mag_q;
  logic [SqW-1:0]     sq_q;
  logic [FrameW-1:0]  fi_q;
  logic [PeriodW-1:0] pc_q;
  logic               launched_q;
  logic [SampleW-1:0] rms_q;
  logic [LevelW-1:0]  pk_q, rm_q;

  logic [SampleW-1:0] peak_q [MaxChannels];
  logic [SumW-1:0]    sum_q  [MaxChannels];
  logic               clip_q [MaxChannels];
  logic [FrameW-1:0]  head_q [MaxChannels];
  logic [FrameW-1:0]  tail_q [MaxChannels];

  logic               ovalid_q;
  logic [ChIdxW-1:0]  o_ch_q;
  logic [LevelW-1:0]  o_pk_q, o_rm_q;
  logic               o_clip_q, o_last_q;
  logic [FrameW-1:0]  o_head_q, o_tail_q, o_frames_q;

  apm_math_req_t      mreq;
  apm_math_rsp_t      mrsp;

  logic [ChCntW-1:0]  eff;
  logic               in_acc, inrange, ch_last, hot, clear_blk, emit;
  logic [SampleW-1:0] in_mag;
  logic [SumW:0]      sum_new;
  logic [FrameW-1:0]  tail_inc;
  logic [PeriodW-1:0] pc_sum;

  assign eff = channels_q == '0 ? ChCntW'(1) :
               (channels_q > ChCntW'(MaxChannels) ? ChCntW'(MaxChannels) : channels_q);
  assign in_acc   = in_i.valid && in_i.ready;
  assign in_mag   = in_i.sample[SampleW-1] ? ~in_i.sample + SampleW'(1) : in_i.sample;
  assign inrange  = {1'b0, idx_q} < eff;
  assign ch_last  = {1'b0, idx_q} == eff - ChCntW'(1);
  assign hot      = mag_q >= hot_q;
  assign sum_new  = {1'b0, sum_q[idx_q]} + {12'd0, sq_q};
  assign tail_inc = tail_q[idx_q] < FrameW'(MaxFrames) ? tail_q[idx_q] + FrameW'(1)
                                                       : tail_q[idx_q];
  assign pc_sum   = pc_q + {12'd0, fi_q};
  assign emit     = state_q == T_EMIT && (!ovalid_q || out_o.ready);
  assign clear_blk = (state_q == T_BEND && pc_sum < {1'b0, period_q}) || (emit && ch_last);

  assign in_i.ready = state_q == T_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channels_q <= 4'd2;
      period_q   <= 24'd4410;
      clip_run_q <= 12'd3;
      hot_q      <= 24'd7549747;
      db_q       <= 1'b1;
      power_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CHANNELS: channels_q <= cfg_data_i[ChCntW-1:0];
        CFG_PERIOD:   period_q   <= cfg_data_i;
        CFG_CLIP_RUN: clip_run_q <= cfg_data_i[11:0];
        CFG_HOT:      hot_q      <= cfg_data_i;
        CFG_DB:       db_q       <= cfg_data_i[0];
        CFG_POWER:    power_q    <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE: if (in_acc) state_d = T_MUL;
      T_MUL:  state_d = T_UPD;
      T_UPD:  state_d = bend_q ? T_BEND : T_IDLE;
      T_BEND: state_d = pc_sum < {1'b0, period_q} ? T_IDLE : T_RMS;
      T_RMS:  if (mrsp.done) state_d = db_q ? T_PKDB : T_EMIT;
      T_PKDB: if (mrsp.done) state_d = T_RMDB;
      T_RMDB: if (mrsp.done) state_d = T_EMIT;
      T_EMIT: if (emit) state_d = ch_last ? T_IDLE : T_RMS;
      default: state_d = T_IDLE;
    endcase
  end

  always_comb begin
    mreq.start  = (state_q == T_RMS || state_q == T_PKDB || state_q == T_RMDB) && !launched_q;
    mreq.op_rms = state_q == T_RMS;
    mreq.power  = power_q;
    mreq.sum    = sum_q[idx_q];
    mreq.frames = fi_q;
    mreq.x      = state_q == T_RMDB ? rms_q : peak_q[idx_q];
  end

  apm_math u_apm_math (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= T_IDLE;
      idx_q      <= '0;
      bend_q     <= 1'b0;
      fi_q       <= '0;
      pc_q       <= '0;
      launched_q <= 1'b0;
      ovalid_q   <= 1'b0;
      for (int i = 0; i < MaxChannels; i++) begin
        peak_q[i] <= '0;
        sum_q[i]  <= '0;
        clip_q[i] <= 1'b0;
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (mreq.start) begin
        launched_q <= 1'b1;
      end else if (mrsp.done) begin
        launched_q <= 1'b0;
      end
      if (in_acc) begin
        idx_q  <= in_i.channel;
        bend_q <= in_i.block_end;
      end
      if (state_q == T_UPD) begin
        if (inrange) begin
          if (mag_q > peak_q[idx_q]) peak_q[idx_q] <= mag_q;
          sum_q[idx_q] <= sum_new[SumW] ? {SumW{1'b1}} : sum_new[SumW-1:0];
          if (hot) begin
            if (head_q[idx_q] == fi_q && head_q[idx_q] < FrameW'(MaxFrames)) begin
              head_q[idx_q] <= head_q[idx_q] + FrameW'(1);
            end
            tail_q[idx_q] <= tail_inc;
            if (tail_inc > {1'b0, clip_run_q}) clip_q[idx_q] <= 1'b1;
          end else begin
            tail_q[idx_q] <= '0;
          end
        end
        if ((ch_last || bend_q) && fi_q < FrameW'(MaxFrames)) fi_q <= fi_q + FrameW'(1);
      end
      if (state_q == T_BEND) begin
        idx_q <= '0;
        pc_q  <= pc_sum < {1'b0, period_q} ? pc_sum : '0;
      end
      if (emit) begin
        idx_q <= idx_q + ChIdxW'(1);
      end
      if (emit) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
      if (clear_blk) begin
        fi_q <= '0;
        for (int i = 0; i < MaxChannels; i++) begin
          peak_q[i] <= '0;
          sum_q[i]  <= '0;
          clip_q[i] <= 1'b0;
          head_q[i] <= '0;
          tail_q[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) mag_q <= in_mag;
    if (state_q == T_MUL) sq_q <= mag_q * mag_q;
    if (state_q == T_RMS && mrsp.done) begin
      rms_q <= mrsp.result[SampleW-1:0];
      pk_q  <= {8'd0, peak_q[idx_q]};
      rm_q  <= mrsp.result;
    end
    if (state_q == T_PKDB && mrsp.done) pk_q <= mrsp.result;
    if (state_q == T_RMDB && mrsp.done) rm_q <= mrsp.result;
    if (emit) begin
      o_ch_q     <= idx_q;
      o_pk_q     <= pk_q;
      o_rm_q     <= rm_q;
      o_clip_q   <= clip_q[idx_q];
      o_head_q   <= head_q[idx_q];
      o_tail_q   <= tail_q[idx_q];
      o_frames_q <= fi_q;
      o_last_q   <= ch_last;
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.out_channel = o_ch_q;
  assign out_o.peak_level  = o_pk_q;
  assign out_o.rms_level   = o_rm_q;
  assign out_o.clipped     = o_clip_q;
  assign out_o.head_run    = o_head_q;
  assign out_o.tail_run    = o_tail_q;
  assign out_o.frame_count = o_frames_q;
  assign out_o.last        = o_last_q;

endmodule

@@ src/apm_checker.sv @@
// Port-level checker of the level meter and its bind to the top level.
`include "audio_peak_rms_clip_meter_assert.svh"

module apm_checker
  import apm_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [FrameW-1:0] head_run_i,
  input logic [FrameW-1:0] frame_count_i
);

  // A result waiting to be taken stays offered.
  `APM_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)

  // The block is busy in the cycle after it takes an item.
  `APM_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i)

  // The opening hot run can never be longer than the block it was counted in.
  `APM_ASSERT_IMP(a_head_in_block, out_valid_i, head_run_i <= frame_count_i)

endmodule

bind audio_peak_rms_clip_meter apm_checker u_apm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .head_run_i    (out_o.head_run),
  .frame_count_i (out_o.frame_count)
);
